FILE: rtl/esutc_pkg.sv
`default_nettype none

package esutc_pkg;

  typedef struct packed {
    logic [39:0] epoch_seconds;
    logic [29:0] nanoseconds;
  } in_item_t;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;
  } out_item_t;

  // 86400 = 128 * 675: the low 7 bits of the seconds bypass the divider
  localparam int unsigned DAY_LO_BITS = 7;
  localparam logic [9:0]  DAY_DIV     = 10'd675;
  // floor reciprocal, quotient may come out one low
  localparam logic [23:0] DAY_RECIP   = 24'((64'd1 << 33) / 64'd675);

  localparam logic [23:0] DAYS_TO_MAR0 = 24'd719468;
  localparam logic [17:0] ERA_DAYS     = 18'd146097;
  localparam logic [17:0] CENT_DAYS    = 18'd36524;
  localparam logic [17:0] LAST_DOE     = 18'd146096;
  localparam logic [17:0] YEAR_DAYS    = 18'd365;
  localparam logic [15:0] ERA_YEARS    = 16'd400;
  localparam logic [8:0]  CENT_YEARS   = 9'd100;
  localparam logic [5:0]  SIXTY        = 6'd60;
  localparam logic [10:0] MS_MAX       = 11'd999;

  // ceiling reciprocals, exact for every input of the stated width
  localparam logic [30:0] MS_RECIP   = 31'(((64'd1 << 50) + 64'd999999) / 64'd1000000);
  localparam logic [24:0] ERA_RECIP  = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
  localparam logic [17:0] MIN_RECIP  = 18'(((64'd1 << 23) + 64'd59) / 64'd60);
  localparam logic [11:0] HR_RECIP   = 12'(((64'd1 << 17) + 64'd59) / 64'd60);
  localparam logic [18:0] Q4Y_RECIP  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << 27) + 64'd364) / 64'd365);

  localparam logic [3:0] MP_JAN = 4'd10;

  // first day of each month, counted in a year that starts on 1 March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/epoch_seconds_to_utc_date_time_unit.sv
// Unix timestamp to UTC civil date and time.
// Input channel: in_valid_i / in_stall_o with in_item_i (seconds since the
// epoch and a nanosecond fraction). Output channel: out_valid_o / out_stall_i
// with out_item_o (year, month, day, hour, minute, second, millisecond).
// An item moves on a rising edge where valid is high and stall is low.
// Eleven register stages; one item is taken every cycle while the output
// keeps flowing. The stage depth is set by the reciprocal multipliers
// (days, era, year of era) and their remainder back-multiplies, one per
// stage.
// When the receiver stalls, the last stage holds its result; stages behind it
// keep filling empty slots, and in_stall_o rises once every stage is full.
// Reset empties the pipeline; out_valid_o is low until the first result.
// The block keeps no other state.
`default_nettype none

module epoch_seconds_to_utc_date_time_unit import esutc_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  wire       out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned NSTG = 11;
  localparam int unsigned LAST = NSTG - 1;

  typedef struct packed {
    logic [32:0] xd;
    logic [6:0]  lo7;
    logic [10:0] ms_raw;
    logic [23:0] dq;
    logic [10:0] dr;
    logic [16:0] sod;
    logic [23:0] z;
    logic [10:0] mtot;
    logic [6:0]  era;
    logic [17:0] doe;
    logic [15:0] ybase;
    logic [6:0]  q4;
    logic [2:0]  cents;
    logic        last_day;
    logic [17:0] t;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [15:0] y;
    logic [3:0]  mp;
    out_item_t   res;
  } pipe_t;

  pipe_t          stg_d [NSTG];
  pipe_t          stg_q [NSTG];
  logic [LAST:0]  vld_d;
  logic [LAST:0]  vld_q;
  logic [LAST:0]  adv;

  always_comb begin
    logic [56:0] day_prod;
    logic [60:0] ms_prod;
    logic [33:0] day_back;
    logic [32:0] day_rem;
    logic        day_carry;
    logic [9:0]  rr;
    logic [48:0] era_prod;
    logic [34:0] min_prod;
    logic [24:0] era_back;
    logic [23:0] doe_w;
    logic [16:0] min_back;
    logic [22:0] hr_prod;
    logic [10:0] hr_back;
    logic [36:0] q4_prod;
    logic [36:0] y_prod;
    logic [1:0]  cent_y;
    logic [17:0] yoe_days;
    logic [17:0] doy_w;
    logic [3:0]  mp;
    logic [8:0]  day_w;

    // stage 0: day and millisecond reciprocals
    stg_d[0]            = '0;
    stg_d[0].xd         = in_item_i.epoch_seconds[39:DAY_LO_BITS];
    stg_d[0].lo7        = in_item_i.epoch_seconds[DAY_LO_BITS-1:0];
    day_prod            = 57'(stg_d[0].xd) * 57'(DAY_RECIP);
    stg_d[0].dq         = day_prod[56:33];
    ms_prod             = 61'(in_item_i.nanoseconds) * 61'(MS_RECIP);
    stg_d[0].ms_raw     = ms_prod[60:50];

    // stage 1: day remainder, millisecond clamp
    stg_d[1]            = stg_q[0];
    day_back            = 34'(stg_q[0].dq) * 34'(DAY_DIV);
    day_rem             = stg_q[0].xd - day_back[32:0];
    stg_d[1].dr         = day_rem[10:0];
    stg_d[1].res.millisecond = (stg_q[0].ms_raw > MS_MAX) ? MS_MAX[9:0]
                                                          : stg_q[0].ms_raw[9:0];

    // stage 2: quotient fix-up, day shift to 0000-03-01, seconds of day
    stg_d[2]            = stg_q[1];
    day_carry           = (stg_q[1].dr >= 11'(DAY_DIV));
    rr                  = day_carry ? 10'(stg_q[1].dr - 11'(DAY_DIV)) : stg_q[1].dr[9:0];
    stg_d[2].z          = stg_q[1].dq + DAYS_TO_MAR0 + 24'(day_carry);
    stg_d[2].sod        = {rr, stg_q[1].lo7};

    // stage 3: era, minutes of day
    stg_d[3]            = stg_q[2];
    era_prod            = 49'(stg_q[2].z) * 49'(ERA_RECIP);
    stg_d[3].era        = era_prod[48:42];
    min_prod            = 35'(stg_q[2].sod) * 35'(MIN_RECIP);
    stg_d[3].mtot       = min_prod[33:23];

    // stage 4: day of era, second, hour, first year of era
    stg_d[4]            = stg_q[3];
    era_back            = 25'(stg_q[3].era) * 25'(ERA_DAYS);
    doe_w               = stg_q[3].z - era_back[23:0];
    stg_d[4].doe        = doe_w[17:0];
    min_back            = 17'(stg_q[3].mtot) * 17'(SIXTY);
    stg_d[4].res.second = 6'(stg_q[3].sod - min_back);
    hr_prod             = 23'(stg_q[3].mtot) * 23'(HR_RECIP);
    stg_d[4].res.hour   = hr_prod[21:17];
    stg_d[4].ybase      = 16'(stg_q[3].era) * ERA_YEARS;

    // stage 5: minute, leap corrections of the day of era
    stg_d[5]            = stg_q[4];
    hr_back             = 11'(stg_q[4].res.hour) * 11'(SIXTY);
    stg_d[5].res.minute = 6'(stg_q[4].mtot - hr_back);
    q4_prod             = 37'(stg_q[4].doe) * 37'(Q4Y_RECIP);
    stg_d[5].q4         = q4_prod[35:29];
    stg_d[5].cents      = 3'(stg_q[4].doe >= CENT_DAYS)
                        + 3'(stg_q[4].doe >= 18'(2 * CENT_DAYS))
                        + 3'(stg_q[4].doe >= 18'(3 * CENT_DAYS))
                        + 3'(stg_q[4].doe >= LAST_DOE);
    stg_d[5].last_day   = (stg_q[4].doe == LAST_DOE);

    // stage 6
    stg_d[6]            = stg_q[5];
    stg_d[6].t          = stg_q[5].doe - 18'(stg_q[5].q4) + 18'(stg_q[5].cents)
                        - 18'(stg_q[5].last_day);

    // stage 7: year of era
    stg_d[7]            = stg_q[6];
    y_prod              = 37'(stg_q[6].t) * 37'(YEAR_RECIP);
    stg_d[7].yoe        = y_prod[35:27];

    // stage 8: day of year (from 1 March), year
    stg_d[8]            = stg_q[7];
    cent_y              = 2'(stg_q[7].yoe >= CENT_YEARS)
                        + 2'(stg_q[7].yoe >= 9'(2 * CENT_YEARS))
                        + 2'(stg_q[7].yoe >= 9'(3 * CENT_YEARS));
    yoe_days            = 18'(stg_q[7].yoe) * YEAR_DAYS + 18'(stg_q[7].yoe[8:2])
                        - 18'(cent_y);
    doy_w               = stg_q[7].doe - yoe_days;
    stg_d[8].doy        = doy_w[8:0];
    stg_d[8].y          = stg_q[7].ybase + 16'(stg_q[7].yoe);

    // stage 9: month index from the March-based start table
    stg_d[9]            = stg_q[8];
    mp                  = '0;
    for (int i = 1; i < 12; i++) begin
      mp = mp + 4'(stg_q[8].doy >= month_start(4'(i)));
    end
    stg_d[9].mp         = mp;

    // stage 10: calendar fields, January and February roll into the next year
    stg_d[10]           = stg_q[9];
    day_w               = stg_q[9].doy - month_start(stg_q[9].mp) + 9'd1;
    stg_d[10].res.day   = day_w[4:0];
    stg_d[10].res.month = (stg_q[9].mp < MP_JAN) ? stg_q[9].mp + 4'd3 : stg_q[9].mp - 4'd9;
    stg_d[10].res.year  = stg_q[9].y + 16'(stg_q[9].mp >= MP_JAN);
  end

  always_comb begin
    adv[LAST] = !vld_q[LAST] || !out_stall_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d = {vld_q[LAST-1:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[LAST];
  assign out_item_o  = stg_q[LAST].res;

endmodule

`default_nettype wire
